// ----- sv/wave_leapfrog_grid_step_top_defines.svh -----
// Assertion macros shared by the wave solver RTL.
`ifndef WAVE_LEAPFROG_GRID_STEP_TOP_DEFINES_SVH
`define WAVE_LEAPFROG_GRID_STEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WLG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/wlg_pkg.sv -----
// Shared types, codes and saturating helpers for the wave solver.
package wlg_pkg;

    localparam int ACC_W = 64;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_STEP = 2'd1,
        ACT_READ = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CFG_COURANT = 2'd0,
        CFG_TIME_STEP = 2'd1,
        CFG_BLOWUP = 2'd2,
        CFG_POINTS = 2'd3
    } t_cfg_index;

    function automatic logic signed [ACC_W-1:0] f_sadd(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if (!a[ACC_W-1] && !b[ACC_W-1] && s[ACC_W-1]) return ACC_MAX;
        if (a[ACC_W-1] && b[ACC_W-1] && !s[ACC_W-1]) return ACC_MIN;
        return s;
    endfunction

    function automatic logic signed [ACC_W-1:0] f_ssub(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        s = a - b;
        if (!a[ACC_W-1] && b[ACC_W-1] && s[ACC_W-1]) return ACC_MAX;
        if (a[ACC_W-1] && !b[ACC_W-1] && !s[ACC_W-1]) return ACC_MIN;
        return s;
    endfunction

    function automatic logic [ACC_W-1:0] f_mag(input logic signed [ACC_W-1:0] a);
        return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    endfunction

endpackage

// ----- sv/wlg_ram.sv -----
// Generic single-write, single-read memory with registered read data.
module wlg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- sv/wave_leapfrog_grid_step_top.sv -----
// Top level of the 1-D leapfrog wave solver with its row memories and sequencer.
//
// Every request returns exactly one result. A step walks the interior points one at a time
// through a single shared 32x26-bit multiplier: each product goes through magnitude, two partial
// products, round and clamp, and accumulate, and a point needs two products on a later step and
// three on the first step after a load or restart. After the sweep the rows rotate at one point
// per cycle, or, on a blow-up, all GRID_MAX entries of the working rows reload from the initial
// store at one entry per cycle. The request port is stalled throughout; a finished result waits
// in the output register.
`include "wave_leapfrog_grid_step_top_defines.svh"

module wave_leapfrog_grid_step_top
    import wlg_pkg::*;
#(
    parameter int GRID_MAX = 1024,
    parameter int VALUE_BITS = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_action,
    input  logic [9:0]                   i_point_index,
    input  logic signed [VALUE_BITS-1:0] i_start_displacement,
    input  logic signed [VALUE_BITS-1:0] i_start_velocity,
    input  logic signed [VALUE_BITS-1:0] i_forcing_term,
    input  logic signed [VALUE_BITS-1:0] i_left_boundary,
    input  logic signed [VALUE_BITS-1:0] i_right_boundary,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [VALUE_BITS-1:0] o_read_value,
    output logic [VALUE_BITS-2:0]        o_peak_magnitude,
    output logic                         o_restarted,
    input  logic                         i_cfg_wr_en,
    input  logic [1:0]                   i_cfg_index,
    input  logic [46:0]                  i_cfg_data
);

    localparam int AW = $clog2(GRID_MAX);
    localparam int NW = $clog2(GRID_MAX + 1);
    localparam int VB = VALUE_BITS;
    localparam logic signed [ACC_W-1:0] VMAXS = ACC_W'((65'(1) << (VB - 1)) - 65'(1));
    localparam logic signed [ACC_W-1:0] VMINS = -VMAXS - ACC_W'(1);

    // Product selectors: velocity term, Laplacian term, forcing term.
    localparam logic [1:0] OP_VEL = 2'd0;
    localparam logic [1:0] OP_LAP = 2'd1;
    localparam logic [1:0] OP_FRC = 2'd2;

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_READ   = 19'h00002,
        S_DT2A   = 19'h00004,
        S_DT2B   = 19'h00008,
        S_PEAK   = 19'h00010,
        S_PRE    = 19'h00020,
        S_FETCH  = 19'h00040,
        S_LAP1   = 19'h00080,
        S_LAP2   = 19'h00100,
        S_MAG    = 19'h00200,
        S_MLO    = 19'h00400,
        S_MHI    = 19'h00800,
        S_MSUM   = 19'h01000,
        S_MACC   = 19'h02000,
        S_WRITE  = 19'h04000,
        S_DECIDE = 19'h08000,
        S_COPY   = 19'h10000,
        S_RELOAD = 19'h20000,
        S_OUT    = 19'h40000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [24:0] r_courant;
    logic [24:0] r_dt;
    logic [46:0] r_limit;
    logic [10:0] r_points;

    // request context
    logic                  r_first;
    logic [9:0]            r_p;
    logic signed [VB-1:0]  r_left, r_right;
    logic [NW-1:0]         r_n;
    logic [NW-1:0]         r_idx;
    logic [25:0]           r_dt2;

    // stencil and product datapath
    logic signed [VB-1:0]    r_wm, r_wc, r_wp, r_old, r_vel, r_frc;
    logic signed [ACC_W-1:0] r_sum, r_twoc, r_lap, r_acc;
    logic [1:0]              r_op;
    logic [ACC_W-1:0]        r_mag;
    logic                    r_neg;
    logic [25:0]             r_k;
    logic                    r_sh25;
    logic [57:0]             r_plo, r_phi;
    logic [ACC_W-1:0]        r_prod;
    logic [ACC_W-1:0]        r_peak;

    // rotation pipeline
    logic          r_cp_v;
    logic [AW-1:0] r_cp_idx;

    // result staging and output register
    logic signed [VB-1:0] r_res_rd;
    logic [VB-2:0]        r_res_peak;
    logic                 r_res_rst;
    logic                 r_o_valid;
    logic signed [VB-1:0] r_o_rd;
    logic [VB-2:0]        r_o_peak;
    logic                 r_o_rst;

    // memories
    logic signed [VB-1:0] cur_q, old_q, next_q, init_q, vel_q, frc_q;
    logic [AW-1:0]        cur_ra, idx_a;
    logic                 cur_we, old_we, next_we, load_we;
    logic [AW-1:0]        cur_wa;
    logic [VB-1:0]        cur_wd, old_wd, next_wd;

    logic                    in_acc, p_in_ok, rot_we, issue;
    logic signed [VB-1:0]    copy_val;
    logic [31:0]             mul_a;
    logic [25:0]             mul_b;
    logic [57:0]             mul_p;
    logic [89:0]             tot, shifted;
    logic signed [ACC_W-1:0] nv64, sel_x, mag_l, mag_r;
    logic [25:0]             sel_k;
    logic [ACC_W-1:0]        nv_mag, pk_l, pk_r;
    logic [31:0]             n_clamp;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc = i_valid && !o_stall;
    assign p_in_ok = 32'(i_point_index) < GRID_MAX;
    assign load_we = in_acc && (i_action == ACT_LOAD) && p_in_ok;
    assign idx_a = r_idx[AW-1:0];
    assign rot_we = r_cp_v && ((r_state == S_COPY) || (r_state == S_RELOAD));

    assign cur_ra = (r_state == S_IDLE) ? AW'(i_point_index)
                  : (r_state == S_FETCH) ? AW'(r_idx + NW'(1)) : idx_a;

    // Endpoints of the new row come from the step request, not from the sweep.
    assign copy_val = (r_cp_idx == '0) ? r_left
                    : (32'(r_cp_idx) == 32'(r_n) - 32'd1) ? r_right : next_q;

    assign cur_we = load_we || rot_we;
    assign old_we = load_we || rot_we;
    assign cur_wa = load_we ? AW'(i_point_index) : r_cp_idx;
    assign cur_wd = load_we ? i_start_displacement
                  : (r_state == S_RELOAD) ? init_q : copy_val;
    assign old_wd = load_we ? i_start_displacement
                  : (r_state == S_RELOAD) ? init_q : cur_q;

    assign nv64 = (r_acc > VMAXS) ? VMAXS : (r_acc < VMINS) ? VMINS : r_acc;
    assign nv_mag = f_mag(nv64);
    assign next_we = (r_state == S_WRITE);
    assign next_wd = nv64[VB-1:0];

    wlg_ram #(.WIDTH(VB), .DEPTH(GRID_MAX)) u_cur_ram (
        .i_clk(i_clk), .i_wr_en(cur_we), .i_wr_addr(cur_wa), .i_wr_data(cur_wd),
        .i_rd_addr(cur_ra), .o_rd_data(cur_q)
    );
    wlg_ram #(.WIDTH(VB), .DEPTH(GRID_MAX)) u_old_ram (
        .i_clk(i_clk), .i_wr_en(old_we), .i_wr_addr(cur_wa), .i_wr_data(old_wd),
        .i_rd_addr(idx_a), .o_rd_data(old_q)
    );
    wlg_ram #(.WIDTH(VB), .DEPTH(GRID_MAX)) u_next_ram (
        .i_clk(i_clk), .i_wr_en(next_we), .i_wr_addr(idx_a), .i_wr_data(next_wd),
        .i_rd_addr(idx_a), .o_rd_data(next_q)
    );
    wlg_ram #(.WIDTH(VB), .DEPTH(GRID_MAX)) u_init_ram (
        .i_clk(i_clk), .i_wr_en(load_we), .i_wr_addr(AW'(i_point_index)),
        .i_wr_data(i_start_displacement), .i_rd_addr(idx_a), .o_rd_data(init_q)
    );
    wlg_ram #(.WIDTH(VB), .DEPTH(GRID_MAX)) u_vel_ram (
        .i_clk(i_clk), .i_wr_en(load_we), .i_wr_addr(AW'(i_point_index)),
        .i_wr_data(i_start_velocity), .i_rd_addr(idx_a), .o_rd_data(vel_q)
    );
    wlg_ram #(.WIDTH(VB), .DEPTH(GRID_MAX)) u_frc_ram (
        .i_clk(i_clk), .i_wr_en(load_we), .i_wr_addr(AW'(i_point_index)),
        .i_wr_data(i_forcing_term), .i_rd_addr(idx_a), .o_rd_data(frc_q)
    );

    // The one shared multiplier: dt squared at step start, then partial products.
    always_comb begin
        mul_a = r_mag[31:0];
        mul_b = r_k;
        if (r_state == S_DT2A) begin
            mul_a = 32'(r_dt);
            mul_b = 26'(r_dt);
        end else if (r_state == S_MHI) begin
            mul_a = r_mag[63:32];
        end
    end
    assign mul_p = 58'(mul_a) * 58'(mul_b);

    // Rounded half up on the magnitude, then clamped to the accumulator's positive range.
    assign tot = {r_phi, 32'b0} + 90'(r_plo) + (r_sh25 ? (90'(1) << 24) : (90'(1) << 23));
    assign shifted = r_sh25 ? (tot >> 25) : (tot >> 24);

    always_comb begin
        case (r_op)
            OP_VEL: begin
                sel_x = ACC_W'(r_vel);
                sel_k = 26'(r_dt);
            end
            OP_LAP: begin
                sel_x = r_lap;
                sel_k = 26'(r_courant);
            end
            default: begin
                sel_x = ACC_W'(r_frc);
                sel_k = r_dt2;
            end
        endcase
    end

    assign mag_l = ACC_W'(r_left);
    assign mag_r = ACC_W'(r_right);
    assign pk_l = f_mag(mag_l);
    assign pk_r = f_mag(mag_r);

    always_comb begin
        n_clamp = 32'(r_points);
        if (n_clamp < 32'd3) n_clamp = 32'd3;
        if (n_clamp > GRID_MAX) n_clamp = GRID_MAX;
    end

    assign issue = (r_state == S_COPY) ? (r_idx < r_n) : (32'(r_idx) < GRID_MAX);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        ACT_STEP: n_state = S_DT2A;
                        ACT_READ: n_state = S_READ;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_READ:   n_state = S_OUT;
            S_DT2A:   n_state = S_DT2B;
            S_DT2B:   n_state = S_PEAK;
            S_PEAK:   n_state = S_PRE;
            S_PRE:    n_state = S_FETCH;
            S_FETCH:  n_state = S_LAP1;
            S_LAP1:   n_state = S_LAP2;
            S_LAP2:   n_state = S_MAG;
            S_MAG:    n_state = S_MLO;
            S_MLO:    n_state = S_MHI;
            S_MHI:    n_state = S_MSUM;
            S_MSUM:   n_state = S_MACC;
            S_MACC:   n_state = (r_op == OP_FRC) ? S_WRITE : S_MAG;
            S_WRITE:  n_state = (32'(r_idx) + 32'd2 < 32'(r_n)) ? S_FETCH : S_DECIDE;
            S_DECIDE: n_state = (r_peak > ACC_W'(r_limit)) ? S_RELOAD : S_COPY;
            S_COPY, S_RELOAD: begin
                if (!issue && !r_cp_v) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || !i_stall) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b1;
            r_o_valid <= 1'b0;
            r_cp_v <= 1'b0;
            r_courant <= 25'd8220836;
            r_dt <= 25'd262144;
            r_limit <= 47'd16777216000000;
            r_points <= 11'd1024;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_COURANT:   r_courant <= i_cfg_data[24:0];
                    CFG_TIME_STEP: r_dt <= i_cfg_data[24:0];
                    CFG_BLOWUP:    r_limit <= i_cfg_data;
                    CFG_POINTS:    r_points <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (load_we) begin
                r_first <= 1'b1;
            end
            if (r_state == S_DECIDE) begin
                r_first <= (r_peak > ACC_W'(r_limit));
            end
            r_cp_v <= ((r_state == S_COPY) || (r_state == S_RELOAD)) && issue;
            if (r_state == S_OUT && (!r_o_valid || !i_stall)) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_p <= i_point_index;
                r_left <= i_left_boundary;
                r_right <= i_right_boundary;
                r_n <= NW'(n_clamp);
                r_idx <= '0;
                r_res_rd <= '0;
                r_res_peak <= '0;
                r_res_rst <= 1'b0;
            end
            S_READ: begin
                r_res_rd <= (32'(r_p) < GRID_MAX) ? cur_q : '0;
            end
            S_DT2A: begin
                r_plo <= mul_p;
            end
            S_DT2B: begin
                r_dt2 <= 26'((r_plo + 58'(1 << 23)) >> 24);
                r_wc <= cur_q;
                r_idx <= NW'(1);
            end
            S_PEAK: begin
                r_peak <= (pk_l > pk_r) ? pk_l : pk_r;
            end
            S_PRE: begin
                r_wm <= r_wc;
                r_wc <= cur_q;
            end
            S_LAP1: begin
                r_wp <= cur_q;
                r_old <= old_q;
                r_vel <= vel_q;
                r_frc <= frc_q;
                r_sum <= f_sadd(ACC_W'(cur_q), ACC_W'(r_wm));
                r_twoc <= f_sadd(ACC_W'(r_wc), ACC_W'(r_wc));
            end
            S_LAP2: begin
                r_lap <= f_ssub(r_sum, r_twoc);
                r_acc <= r_first ? ACC_W'(r_wc) : f_ssub(r_twoc, ACC_W'(r_old));
                r_op <= r_first ? OP_VEL : OP_LAP;
            end
            S_MAG: begin
                r_mag <= f_mag(sel_x);
                r_neg <= sel_x[ACC_W-1];
                r_k <= sel_k;
                r_sh25 <= r_first && (r_op != OP_VEL);
            end
            S_MLO: begin
                r_plo <= mul_p;
            end
            S_MHI: begin
                r_phi <= mul_p;
            end
            S_MSUM: begin
                r_prod <= (shifted > 90'(ACC_MAX)) ? ACC_W'(ACC_MAX) : shifted[ACC_W-1:0];
            end
            S_MACC: begin
                r_acc <= f_sadd(r_acc, r_neg ? -signed'(r_prod) : signed'(r_prod));
                r_op <= r_op + 2'd1;
            end
            S_WRITE: begin
                if (nv_mag > r_peak) r_peak <= nv_mag;
                r_wm <= r_wc;
                r_wc <= r_wp;
                r_idx <= r_idx + NW'(1);
            end
            S_DECIDE: begin
                r_res_peak <= (r_peak > ACC_W'(VMAXS)) ? VMAXS[VB-2:0] : r_peak[VB-2:0];
                r_res_rst <= (r_peak > ACC_W'(r_limit));
                r_idx <= '0;
            end
            S_COPY, S_RELOAD: begin
                r_cp_idx <= idx_a;
                if (issue) r_idx <= r_idx + NW'(1);
            end
            S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    r_o_rd <= r_res_rd;
                    r_o_peak <= r_res_peak;
                    r_o_rst <= r_res_rst;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_o_valid;
    assign o_read_value = r_o_rd;
    assign o_peak_magnitude = r_o_peak;
    assign o_restarted = r_o_rst;

    `WLG_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, in_acc, o_stall,
                     "request not held off")
    `WLG_ASSERT_NOW(a_restart_has_peak, i_clk, i_rst_n, r_o_valid && r_o_rst,
                    r_o_peak != '0, "restart without peak")
    `WLG_ASSERT_NOW(a_read_no_step, i_clk, i_rst_n, r_o_valid && (r_o_rd != '0),
                    (r_o_peak == '0) && !r_o_rst, "read and step fields mixed")

endmodule

// ----- sim/wave_leapfrog_grid_step_checker.sv -----
// Watches the wave solver's channels, predicts every result and compares it with the block.
module wave_leapfrog_grid_step_checker
    import wlg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic [9:0]         i_point_index,
    input  logic signed [47:0] i_start_displacement,
    input  logic signed [47:0] i_start_velocity,
    input  logic signed [47:0] i_forcing_term,
    input  logic signed [47:0] i_left_boundary,
    input  logic signed [47:0] i_right_boundary,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [47:0] o_read_value,
    input  logic [46:0]        o_peak_magnitude,
    input  logic               o_restarted,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [46:0]        i_cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 steps_seen,
    output int                 restarts_seen,
    output int                 reads_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 1024;
    localparam logic signed [63:0] WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] WIDE_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] PT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] PT_MIN = -PT_MAX - 64'sd1;

    typedef struct {
        logic signed [47:0] rd;
        logic [46:0]        pk;
        logic               rs;
    } t_outcome;

    t_outcome outcome_q[$];

    logic signed [63:0] prev_disp [NPTS];
    logic signed [63:0] cur_disp [NPTS];
    logic signed [63:0] new_disp [NPTS];
    logic signed [63:0] init_disp [NPTS];
    logic signed [63:0] init_vel [NPTS];
    logic signed [63:0] drive [NPTS];
    logic               taylor_start;
    logic [24:0]        courant2;
    logic [24:0]        dt;
    logic [46:0]        limit;
    logic [10:0]        npts_cfg;

    function automatic logic signed [63:0] clamp_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? WIDE_MIN : WIDE_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_sub(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? WIDE_MIN : WIDE_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] magnitude(logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    // x*k/2^s on the magnitude, rounded half up, saturated, then the sign of x restored.
    function automatic logic signed [63:0] scaled(logic signed [63:0] x, logic [63:0] k, int s);
        logic [63:0]  m, hi, lo;
        logic [127:0] low, r;
        m = magnitude(x);
        hi = m >> s;
        lo = m & ((64'd1 << s) - 64'd1);
        low = ({64'd0, lo} * {64'd0, k} + (128'd1 << (s - 1))) >> s;
        r = {64'd0, hi} * {64'd0, k} + low;
        if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
        return x[63] ? -$signed(r[63:0]) : $signed(r[63:0]);
    endfunction

    function automatic logic signed [63:0] fit_point(logic signed [63:0] a);
        if (a > PT_MAX) return PT_MAX;
        if (a < PT_MIN) return PT_MIN;
        return a;
    endfunction

    function automatic t_outcome advance_grid(logic signed [47:0] left, logic signed [47:0] right);
        t_outcome           o;
        int                 n;
        logic [63:0]        dt_sq, peak, m;
        logic signed [63:0] c, twoc, lap, acc;
        o = '{default: 0};
        n = npts_cfg;
        if (n < 3) n = 3;
        if (n > NPTS) n = NPTS;
        dt_sq = (64'(dt) * 64'(dt) + 64'd8388608) >> 24;
        for (int i = 1; i + 1 < n; i++) begin
            c = cur_disp[i];
            twoc = clamp_add(c, c);
            lap = clamp_sub(clamp_add(cur_disp[i+1], cur_disp[i-1]), twoc);
            if (taylor_start) begin
                acc = clamp_add(c, scaled(init_vel[i], 64'(dt), 24));
                acc = clamp_add(acc, scaled(lap, 64'(courant2), 25));
                acc = clamp_add(acc, scaled(drive[i], dt_sq, 25));
            end else begin
                acc = clamp_sub(twoc, prev_disp[i]);
                acc = clamp_add(acc, scaled(lap, 64'(courant2), 24));
                acc = clamp_add(acc, scaled(drive[i], dt_sq, 24));
            end
            new_disp[i] = fit_point(acc);
        end
        new_disp[0] = left;
        new_disp[n-1] = right;
        peak = 0;
        for (int i = 0; i < n; i++) begin
            m = magnitude(new_disp[i]);
            if (m > peak) peak = m;
        end
        o.pk = (peak > 64'(PT_MAX)) ? PT_MAX[46:0] : peak[46:0];
        if (peak > 64'(limit)) begin
            for (int i = 0; i < NPTS; i++) begin
                prev_disp[i] = init_disp[i];
                cur_disp[i] = init_disp[i];
            end
            taylor_start = 1'b1;
            o.rs = 1'b1;
        end else begin
            for (int i = 0; i < n; i++) begin
                prev_disp[i] = cur_disp[i];
                cur_disp[i] = new_disp[i];
            end
            taylor_start = 1'b0;
        end
        return o;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
        steps_seen = 0;
        restarts_seen = 0;
        reads_seen = 0;
    end

    always @(posedge i_clk) begin
        t_outcome want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < NPTS; i++) begin
                prev_disp[i] = 0;
                cur_disp[i] = 0;
                new_disp[i] = 0;
                init_disp[i] = 0;
                init_vel[i] = 0;
                drive[i] = 0;
            end
            taylor_start = 1'b1;
            courant2 = 25'd8220836;
            dt = 25'd262144;
            limit = 47'd16777216000000;
            npts_cfg = 11'd1024;
            outcome_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_COURANT:   courant2 = i_cfg_data[24:0];
                    CFG_TIME_STEP: dt = i_cfg_data[24:0];
                    CFG_BLOWUP:    limit = i_cfg_data;
                    CFG_POINTS:    npts_cfg = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                got = '{rd: o_read_value, pk: o_peak_magnitude, rs: o_restarted};
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with nothing expected: read %h peak %h restart %b",
                             $realtime, got.rd, got.pk, got.rs);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.rd !== want.rd) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $realtime, want.rd, got.rd);
                        fail_count++;
                    end
                    if (got.pk !== want.pk) begin
                        $display("%0t: peak_magnitude expected %h actual %h",
                                 $realtime, want.pk, got.pk);
                        fail_count++;
                    end
                    if (got.rs !== want.rs) begin
                        $display("%0t: restarted expected %b actual %b",
                                 $realtime, want.rs, got.rs);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                want = '{default: 0};
                case (t_action'(i_action))
                    ACT_LOAD: begin
                        init_disp[i_point_index] = i_start_displacement;
                        prev_disp[i_point_index] = i_start_displacement;
                        cur_disp[i_point_index] = i_start_displacement;
                        init_vel[i_point_index] = i_start_velocity;
                        drive[i_point_index] = i_forcing_term;
                        taylor_start = 1'b1;
                    end
                    ACT_STEP: begin
                        want = advance_grid(i_left_boundary, i_right_boundary);
                        steps_seen++;
                        if (want.rs) restarts_seen++;
                    end
                    ACT_READ: begin
                        want.rd = cur_disp[i_point_index][47:0];
                        reads_seen++;
                    end
                    default: ;
                endcase
                outcome_q.push_back(want);
            end
        end
        pending = outcome_q.size();
    end
endmodule

// ----- sim/tb.sv -----
// Stimulus, clock, reset and verdict for the wave solver, with the checker beside the block.
module tb;
    import wlg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [47:0] P_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] P_MIN = 48'sh8000_0000_0000;
    localparam logic signed [47:0] ONE = 48'sd16777216;
    localparam int NPHASE = 7;
    localparam int FILL = 64;
    localparam int NREQ = 70;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic               i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic [1:0]         i_action;
    logic [9:0]         i_point_index;
    logic signed [47:0] i_start_displacement, i_start_velocity, i_forcing_term;
    logic signed [47:0] i_left_boundary, i_right_boundary, o_read_value;
    logic [46:0]        o_peak_magnitude;
    logic               o_restarted;
    logic               i_cfg_wr_en;
    logic [1:0]         i_cfg_index;
    logic [46:0]        i_cfg_data;
    int                 fail_count, pending, steps_seen, restarts_seen, reads_seen;
    logic               calm;

    wave_leapfrog_grid_step_top u_dut (.*);

    wave_leapfrog_grid_step_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timeout with %0d results outstanding", pending);
        $display("** wave_leapfrog_grid_step_top: FAILED **");
        $finish;
    end

    // The receiving side stalls at random except during the calm stretch.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall = !calm && ($urandom_range(99) < 38);
        end
    end

    function automatic logic signed [47:0] any_value();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0: return P_MAX;
            1: return P_MIN;
            2: return '0;
            3, 4: return {16'($urandom), w};
            default: return {{20{w[27]}}, w[27:0]};
        endcase
    endfunction

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [46:0] value);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic send(t_action act, logic [9:0] idx, logic signed [47:0] d,
                        logic signed [47:0] v, logic signed [47:0] f,
                        logic signed [47:0] lb, logic signed [47:0] rb);
        if (!calm && $urandom_range(99) < 38) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_action = act;
        i_point_index = idx;
        i_start_displacement = d;
        i_start_velocity = v;
        i_forcing_term = f;
        i_left_boundary = lb;
        i_right_boundary = rb;
        i_valid = 1'b1;
        #1;
        while (o_stall) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
    endtask

    task automatic small_load(logic [9:0] idx);
        send(ACT_LOAD, idx, any_value() >>> 8, any_value() >>> 10, any_value() >>> 12, 0, 0);
    endtask

    initial begin
        logic [24:0] r2_set [NPHASE];
        logic [24:0] dt_set [NPHASE];
        logic [46:0] lim_set [NPHASE];
        logic [10:0] n_set [NPHASE];
        int          steps_left, span;
        logic [9:0]  idx;
        logic [1:0]  act;

        r2_set = '{25'd8220836, 25'd0, 25'd16777216, 25'h1FFFFFF, 25'd4000000, 25'd8220836,
                   25'd12000000};
        dt_set = '{25'd262144, 25'd0, 25'd16777216, 25'h1FFFFFF, 25'd1000000, 25'd262144,
                   25'd500000};
        lim_set = '{47'd16777216000000, 47'd0, 47'h7FFF_FFFF_FFFF, 47'h4000_0000_0000,
                    47'd1073741824, 47'd16777216000000, 47'h5555_5555_5555};
        n_set = '{11'd8, 11'd3, 11'd12, 11'd2, 11'd20, 11'd0, 11'd64};

        calm = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_LOAD;
        i_point_index = '0;
        i_start_displacement = '0;
        i_start_velocity = '0;
        i_forcing_term = '0;
        i_left_boundary = '0;
        i_right_boundary = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_COURANT;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // The low points get written first; no step and no read goes beyond them.
        for (int p = 0; p < FILL; p++) small_load(10'(p));
        i_valid = 1'b0;
        drain();
        write_reg(CFG_POINTS, 47'(FILL));
        send(ACT_STEP, 0, 0, 0, 0, ONE, -ONE);
        send(ACT_STEP, 0, 0, 0, 0, 0, 0);
        send(ACT_READ, 10'(FILL - 1), 0, 0, 0, 0, 0);
        i_valid = 1'b0;
        drain();

        // Directed: field extremes, saturation, restart and the unused action code.
        write_reg(CFG_POINTS, 47'd8);
        send(ACT_LOAD, 10'd1, P_MAX, 0, 0, 0, 0);
        send(ACT_LOAD, 10'd2, P_MIN, P_MAX, P_MIN, 0, 0);
        send(ACT_LOAD, 10'd3, 0, P_MIN, P_MAX, 0, 0);
        send(ACT_READ, 10'd1, 0, 0, 0, 0, 0);
        send(ACT_READ, 10'd2, 0, 0, 0, 0, 0);
        send(ACT_READ, 10'(FILL - 1), 0, 0, 0, 0, 0);
        send(ACT_STEP, 0, 0, 0, 0, P_MIN, P_MAX);
        send(ACT_READ, 10'd1, 0, 0, 0, 0, 0);
        for (int p = 1; p < 7; p++) send(ACT_LOAD, 10'(p), ONE * p, -ONE, ONE >>> 2, 0, 0);
        send(ACT_STEP, 0, 0, 0, 0, 0, 0);
        send(ACT_STEP, 0, 0, 0, 0, ONE, ONE);
        send(ACT_READ, 10'd3, 0, 0, 0, 0, 0);
        send(ACT_READ, 10'd7, 0, 0, 0, 0, 0);
        send(ACT_STEP, 0, 0, 0, 0, P_MAX, P_MIN);
        send(t_action'(ACT_SPARE), 10'h3FF, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX);
        send(ACT_READ, 10'd0, 0, 0, 0, 0, 0);
        i_valid = 1'b0;
        drain();

        for (int ph = 0; ph < NPHASE; ph++) begin
            write_reg(CFG_COURANT, 47'(r2_set[ph]));
            write_reg(CFG_TIME_STEP, 47'(dt_set[ph]));
            write_reg(CFG_BLOWUP, lim_set[ph]);
            write_reg(CFG_POINTS, 47'(n_set[ph]));
            calm = (ph == 2);
            steps_left = (ph == NPHASE - 1) ? 1 : 1000;
            span = (n_set[ph] < 3 || n_set[ph] > 24) ? 24 : int'(n_set[ph]);
            for (int k = 0; k < NREQ; k++) begin
                if (ph == 1 && k == 40) begin
                    i_valid = 1'b0;
                    drain();
                end
                idx = ($urandom_range(9) == 0) ? 10'($urandom_range(FILL - 1))
                                               : 10'($urandom_range(span - 1));
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5: act = ACT_LOAD;
                    6, 7, 8, 9, 10, 11, 12, 13: act = ACT_STEP;
                    19: act = ACT_SPARE;
                    default: act = ACT_READ;
                endcase
                if (act == ACT_STEP) begin
                    if (steps_left == 0) act = ACT_READ;
                    else steps_left--;
                end
                if (act == ACT_LOAD && $urandom_range(3) != 0) begin
                    small_load(idx);
                end else begin
                    send(t_action'(act), idx, any_value(), any_value(), any_value(),
                         ($urandom_range(3) == 0) ? any_value() : any_value() >>> 16,
                         ($urandom_range(3) == 0) ? any_value() : any_value() >>> 16);
                end
            end
            i_valid = 1'b0;
            calm = 1'b0;
            drain();
        end

        repeat (100) @(negedge i_clk);
        $display("Covered %0d steps (%0d restarts) and %0d reads over %0d register settings,",
                 steps_seen, restarts_seen, reads_seen, NPHASE + 2);
        $display("including clamped grid sizes, zero and full-scale coefficients.");
        if (fail_count == 0) begin
            $display("** wave_leapfrog_grid_step_top: PASSED **");
        end else begin
            $display("** wave_leapfrog_grid_step_top: FAILED **");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/wlg_pkg.sv
sv/wlg_ram.sv
sv/wave_leapfrog_grid_step_top.sv
sim/wave_leapfrog_grid_step_checker.sv
sim/tb.sv
